[design/npd_pkg.sv]
// Shared widths, item codes, feature constants and the divider control word
// for the pixel pair feature block. No dependencies.
package npd_pkg;

   // Field widths fixed by the item format.
   localparam int POS_W = 10;
   localparam int PIX_W = 8;
   localparam int FEATURE_W = 8;

   // Divider operands: the pixel sum needs one bit more than a pixel.
   localparam int DIV_W = PIX_W + 1;

   // Default patch size.
   localparam int PATCH_PIXELS_DEFAULT = 1024;

   // Item kinds.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Feature codes for the special cases.
   localparam logic [FEATURE_W-1:0] FEATURE_TIE = 8'd128;
   localparam logic [FEATURE_W-1:0] FEATURE_MAX = 8'd255;

   // Control word that travels with each query through the divider.
   typedef struct packed {
      logic valid;
      logic tie;
      logic sat;
   } div_ctrl_type;

endpackage

[design/npd_pixel_pair_feature.sv]
// Top level of the pixel pair feature block: pixel store, operand stage and
// the pipelined divider. Depends on npd_pkg and npd_divider.
//
//   channel   ports                                   handshake
//   request   req_kind req_first_pos req_pixel_value  start, taken when busy low
//             req_second_pos
//   response  rsp_feature                             rsp_valid, one cycle strobe
//
// One word is taken every cycle; busy stays low. A query's feature passes the
// registers in order: the store read registers at the edge that takes the word,
// then the operand stage, then the two divider stages, and the divider
// resolves four quotient bits per stage. A write takes effect at the edge that
// takes it, so a query in the very next cycle sees it. Reset clears the stage
// valid bits only; the pixel store holds unknown values until written. The
// receiver cannot stall, so the pipeline never holds.
module npd_pixel_pair_feature
   import npd_pkg::*;
#(
   parameter int PATCH_PIXELS = PATCH_PIXELS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [POS_W-1:0]     req_first_pos,
   input  logic [PIX_W-1:0]     req_pixel_value,
   input  logic [POS_W-1:0]     req_second_pos,
   output logic                 rsp_valid,
   output logic [FEATURE_W-1:0] rsp_feature
);

   localparam int ADDR_W = $clog2(PATCH_PIXELS);
   localparam int EXT_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

   logic                 accept;
   logic                 first_ok, second_ok;
   logic [EXT_W-1:0]     first_ext, second_ext;
   logic [ADDR_W-1:0]    first_addr, second_addr;

   logic [PIX_W-1:0]     patch_store_ff [PATCH_PIXELS];

   logic                 rd_valid_ff, rd_valid_in;
   logic                 rd_a_ok_ff, rd_b_ok_ff;
   logic [PIX_W-1:0]     rd_pix_a_ff, rd_pix_b_ff;

   div_ctrl_type         op_ctrl_ff, op_ctrl_in;
   logic [DIV_W-1:0]     op_rem_ff, op_rem_in;
   logic [DIV_W-1:0]     op_sum_ff, op_sum_in;

   // The pipeline never stalls, so every word is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Positions beyond the patch are dropped on write and read as zero.
   assign first_ok    = 32'(req_first_pos) < PATCH_PIXELS;
   assign second_ok   = 32'(req_second_pos) < PATCH_PIXELS;
   assign first_ext   = EXT_W'(req_first_pos);
   assign second_ext  = EXT_W'(req_second_pos);
   assign first_addr  = first_ext[ADDR_W-1:0];
   assign second_addr = second_ext[ADDR_W-1:0];

   // Pixel store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_WRITE && first_ok) begin
         patch_store_ff[first_addr] <= req_pixel_value;
      end
      rd_pix_a_ff <= patch_store_ff[first_addr];
      rd_pix_b_ff <= patch_store_ff[second_addr];
   end

   // Read stage control.
   assign rd_valid_in = accept && req_kind == KIND_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
      rd_a_ok_ff <= first_ok;
      rd_b_ok_ff <= second_ok;
   end

   // Operand stage: mask out-of-patch pixels, form the sum and the special flags.
   always_comb begin
      logic [PIX_W-1:0] pix_a;
      logic [PIX_W-1:0] pix_b;
      pix_a = rd_a_ok_ff ? rd_pix_a_ff : '0;
      pix_b = rd_b_ok_ff ? rd_pix_b_ff : '0;
      op_sum_in        = {1'b0, pix_a} + {1'b0, pix_b};
      op_rem_in        = {1'b0, pix_a};
      op_ctrl_in.valid = rd_valid_ff;
      op_ctrl_in.tie   = (pix_a == '0) && (pix_b == '0);
      op_ctrl_in.sat   = (pix_b == '0) && (pix_a != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ctrl_ff.valid <= 1'b0;
      end else begin
         op_ctrl_ff.valid <= op_ctrl_in.valid;
      end
      op_ctrl_ff.tie <= op_ctrl_in.tie;
      op_ctrl_ff.sat <= op_ctrl_in.sat;
      op_rem_ff      <= op_rem_in;
      op_sum_ff      <= op_sum_in;
   end

   // Quotient and final code.
   npd_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_ctrl     (op_ctrl_ff),
      .in_rem      (op_rem_ff),
      .in_sum      (op_sum_ff),
      .out_valid   (rsp_valid),
      .out_feature (rsp_feature)
   );

`ifndef SYNTHESIS
   // The block never holds off a request word.
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy was raised");

   // The response strobe is always a known value out of reset.
   a_rsp_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("response strobe is unknown");

   // Every query word gives a response.
   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_QUERY) |-> ##4 rsp_valid)
      else $error("query word gave no response");

   // A write word never produces a response.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_WRITE) |-> ##4 !rsp_valid)
      else $error("write word produced a response");
`endif

endmodule

[design/npd_divider.sv]
// Two-stage pipelined restoring divider that forms floor(256*a/(a+b)) and
// applies the tie and saturation codes. Depends on npd_pkg.
module npd_divider
   import npd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         in_ctrl,
   input  logic [DIV_W-1:0]     in_rem,
   input  logic [DIV_W-1:0]     in_sum,
   output logic                 out_valid,
   output logic [FEATURE_W-1:0] out_feature
);

   localparam int HALF = FEATURE_W / 2;

   // One restoring step: double the remainder and subtract the divisor if it fits.
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic [DIV_W-1:0] den);
      logic [DIV_W:0] dbl;
      logic [DIV_W:0] diff;
      dbl  = {rem, 1'b0};
      diff = dbl - {1'b0, den};
      if (dbl >= {1'b0, den}) begin
         return {1'b1, diff[DIV_W-1:0]};
      end
      return {1'b0, dbl[DIV_W-1:0]};
   endfunction

   div_ctrl_type         ctrl_a_ff, ctrl_a_in;
   logic [DIV_W-1:0]     rem_a_ff, rem_a_in;
   logic [DIV_W-1:0]     sum_a_ff;
   logic [HALF-1:0]      quo_a_ff, quo_a_in;
   logic                 valid_ff, valid_in;
   logic [FEATURE_W-1:0] feature_ff, feature_in;

   // First stage: the upper half of the quotient bits.
   always_comb begin
      logic [DIV_W-1:0] rem_v;
      logic [DIV_W:0]   step_v;
      rem_v    = in_rem;
      quo_a_in = '0;
      for (int i = 0; i < HALF; i++) begin
         step_v = div_step(rem_v, in_sum);
         quo_a_in[HALF-1-i] = step_v[DIV_W];
         rem_v = step_v[DIV_W-1:0];
      end
      rem_a_in  = rem_v;
      ctrl_a_in = in_ctrl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff.valid <= 1'b0;
      end else begin
         ctrl_a_ff.valid <= ctrl_a_in.valid;
      end
      ctrl_a_ff.tie <= ctrl_a_in.tie;
      ctrl_a_ff.sat <= ctrl_a_in.sat;
      rem_a_ff      <= rem_a_in;
      sum_a_ff      <= in_sum;
      quo_a_ff      <= quo_a_in;
   end

   // Second stage: the lower half of the quotient, then the special codes.
   always_comb begin
      logic [DIV_W-1:0] rem_v;
      logic [DIV_W:0]   step_v;
      logic [HALF-1:0]  quo_b;
      rem_v = rem_a_ff;
      quo_b = '0;
      for (int i = 0; i < HALF; i++) begin
         step_v = div_step(rem_v, sum_a_ff);
         quo_b[HALF-1-i] = step_v[DIV_W];
         rem_v = step_v[DIV_W-1:0];
      end
      if (ctrl_a_ff.tie) begin
         feature_in = FEATURE_TIE;
      end else if (ctrl_a_ff.sat) begin
         feature_in = FEATURE_MAX;
      end else begin
         feature_in = {quo_a_ff, quo_b};
      end
      valid_in = ctrl_a_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      feature_ff <= feature_in;
   end

   assign out_valid   = valid_ff;
   assign out_feature = feature_ff;

`ifndef SYNTHESIS
   // Every operand word leaves the divider.
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      in_ctrl.valid |-> ##2 out_valid)
      else $error("divider dropped a word");

   // Two zero pixels always come out as the tie code.
   a_tie_code: assert property (@(posedge clock) disable iff (reset)
      (in_ctrl.valid && in_ctrl.tie) |-> ##2 (out_valid && out_feature == FEATURE_TIE))
      else $error("tie case did not give the tie code");

   // A zero second pixel with a nonzero first saturates.
   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      (in_ctrl.valid && in_ctrl.sat && !in_ctrl.tie) |->
         ##2 (out_valid && out_feature == FEATURE_MAX))
      else $error("saturation case did not give the maximum code");
`endif

endmodule

[tb/sv/npd_pixel_pair_feature_tb.sv]
`timescale 1ns / 1ps
// Testbench for npd_pixel_pair_feature: pixel writes and pair queries go in
// through the start/busy port, and each feature word is checked against a
// predictor that mirrors the pixel store. Depends on npd_pkg and the block.
module npd_pixel_pair_feature_tb;
   import npd_pkg::*;

   localparam int PATCH_PIXELS = PATCH_PIXELS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [FEATURE_W-1:0] feature;
      logic [POS_W-1:0]     pos_a;
      logic [POS_W-1:0]     pos_b;
   } pending_feature_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_kind;
   logic [POS_W-1:0]     req_first_pos;
   logic [PIX_W-1:0]     req_pixel_value;
   logic [POS_W-1:0]     req_second_pos;
   logic                 rsp_valid;
   logic [FEATURE_W-1:0] rsp_feature;

   // Shadow of the pixel store and the positions written since reset.
   logic [PIX_W-1:0]     pixel_shadow [PATCH_PIXELS];
   bit                   written_map [PATCH_PIXELS];
   logic [POS_W-1:0]     written_positions [$];
   pending_feature_type  pending_features [$];

   int  error_count = 0;
   int  watchdog_count = 0;
   bit  idle_enable = 1'b0;

   npd_pixel_pair_feature #(
      .PATCH_PIXELS (PATCH_PIXELS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_first_pos   (req_first_pos),
      .req_pixel_value (req_pixel_value),
      .req_second_pos  (req_second_pos),
      .rsp_valid       (rsp_valid),
      .rsp_feature     (rsp_feature)
   );

   always #4 clock = ~clock;

   // Normalized pixel difference of a pair, saturated, with the tie code.
   function automatic logic [FEATURE_W-1:0] npd_feature(input logic [PIX_W-1:0] a,
                                                        input logic [PIX_W-1:0] b);
      logic [DIV_W-1:0] pair_sum;
      logic [15:0]      scaled;
      logic [15:0]      quotient;
      pair_sum = {1'b0, a} + {1'b0, b};
      if (pair_sum == '0) return FEATURE_TIE;
      scaled = {a, 8'h00};
      quotient = scaled / pair_sum;
      if (quotient > 16'd255) return FEATURE_MAX;
      return quotient[FEATURE_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] shadow_pixel(input logic [POS_W-1:0] pos);
      if (pos >= PATCH_PIXELS) return '0;
      return pixel_shadow[pos];
   endfunction

   // Pixel values lean toward zero and full scale to reach the special cases.
   function automatic logic [PIX_W-1:0] draw_pixel();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return 8'd0;
      if (roll < 30) return 8'd255;
      if (roll < 45) return 8'($urandom_range(0, 3));
      if (roll < 50) return 8'($urandom_range(252, 255));
      return 8'($urandom);
   endfunction

   // Write positions favor a small hot region so pixels get overwritten.
   function automatic logic [POS_W-1:0] draw_write_pos();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 10'($urandom_range(0, 15));
      if (roll < 30) return 10'(PATCH_PIXELS - 1);
      return 10'($urandom_range(0, PATCH_PIXELS - 1));
   endfunction

   function automatic logic [POS_W-1:0] pick_written();
      return written_positions[$urandom_range(0, written_positions.size() - 1)];
   endfunction

   // Sends one word, after a random gap when gaps are enabled, and records what it should produce.
   task automatic send_word(input logic kind, input logic [POS_W-1:0] first_pos,
                            input logic [PIX_W-1:0] pixel_value,
                            input logic [POS_W-1:0] second_pos);
      int unsigned         gap;
      pending_feature_type entry;
      gap = idle_enable ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         start           <= 1'b0;
         req_kind        <= 1'($urandom);
         req_first_pos   <= 10'($urandom);
         req_pixel_value <= 8'($urandom);
         req_second_pos  <= 10'($urandom);
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_first_pos   <= first_pos;
      req_pixel_value <= pixel_value;
      req_second_pos  <= second_pos;
      do @(posedge clock); while (busy !== 1'b0);

      // The word was taken at this edge.
      if (kind == KIND_WRITE) begin
         if (first_pos < PATCH_PIXELS) begin
            if (!written_map[first_pos]) begin
               written_map[first_pos] = 1'b1;
               written_positions = {written_positions, first_pos};
            end
            pixel_shadow[first_pos] = pixel_value;
         end
      end else begin
         entry.feature = npd_feature(shadow_pixel(first_pos), shadow_pixel(second_pos));
         entry.pos_a = first_pos;
         entry.pos_b = second_pos;
         pending_features = {pending_features, entry};
      end
   endtask

   task automatic write_pixel(input logic [POS_W-1:0] pos, input logic [PIX_W-1:0] value);
      send_word(KIND_WRITE, pos, value, 10'($urandom));
   endtask

   task automatic query_pair(input logic [POS_W-1:0] pos_a, input logic [POS_W-1:0] pos_b);
      send_word(KIND_QUERY, pos_a, 8'($urandom), pos_b);
   endtask

   // Field extremes and every special case of the feature code.
   task automatic test_directed_extremes();
      idle_enable = 1'b0;
      write_pixel(10'd0, 8'd0);
      write_pixel(10'd1023, 8'd255);
      write_pixel(10'd1, 8'd255);
      write_pixel(10'd2, 8'd0);
      write_pixel(10'd512, 8'd1);
      write_pixel(10'd3, 8'd128);
      write_pixel(10'h155, 8'hAA);
      send_word(KIND_WRITE, 10'h2AA, 8'h55, 10'h3FF);
      // Both pixels zero gives the tie code.
      query_pair(10'd0, 10'd2);
      // Second pixel zero saturates the quotient.
      query_pair(10'd1023, 10'd0);
      query_pair(10'd0, 10'd1023);
      query_pair(10'd1023, 10'd1);
      query_pair(10'd512, 10'd1023);
      query_pair(10'd1023, 10'd512);
      query_pair(10'd3, 10'd1);
      send_word(KIND_QUERY, 10'h155, 8'hFF, 10'h2AA);
      send_word(KIND_QUERY, 10'h2AA, 8'h00, 10'h155);
      query_pair(10'd1023, 10'd1023);
      // A query right behind a write must see the new pixel.
      write_pixel(10'd0, 8'd7);
      query_pair(10'd0, 10'd0);
      write_pixel(10'd2, 8'd200);
      query_pair(10'd0, 10'd2);
   endtask

   // Random mix of writes, read-after-write pairs and queries of stored pixels.
   task automatic run_random_mix(input int count);
      int unsigned      roll;
      logic [POS_W-1:0] pos;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35 || written_positions.size() == 0) begin
            write_pixel(draw_write_pos(), draw_pixel());
         end else if (roll < 45) begin
            pos = draw_write_pos();
            write_pixel(pos, draw_pixel());
            if ($urandom_range(0, 1) == 0) query_pair(pos, pick_written());
            else query_pair(pick_written(), pos);
         end else if (roll < 52) begin
            pos = pick_written();
            query_pair(pos, pos);
         end else begin
            query_pair(pick_written(), pick_written());
         end
      end
   endtask

   task automatic test_random_back_to_back();
      idle_enable = 1'b0;
      run_random_mix(200);
   endtask

   task automatic test_random_gaps();
      for (int round = 0; round < 4; round++) begin
         idle_enable = 1'b1;
         run_random_mix(75);
         idle_enable = 1'b0;
         run_random_mix(25);
      end
   endtask

   // Every feature word is matched against the oldest pending query.
   always @(posedge clock) begin
      pending_feature_type entry;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_features.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: feature word %0d with no query pending", $realtime,
                        rsp_feature);
         end else begin
            entry = pending_features.pop_front();
            if (rsp_feature !== entry.feature) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: feature of pair (%0d, %0d): expected %0d, got %0d",
                           $realtime, entry.pos_a, entry.pos_b, entry.feature,
                           rsp_feature);
            end
         end
      end
   end

   // Ends the run when nothing moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         watchdog_count <= 0;
      end else if (watchdog_count + 1 >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         watchdog_count <= watchdog_count + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_kind        <= KIND_WRITE;
      req_first_pos   <= '0;
      req_pixel_value <= '0;
      req_second_pos  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_random_back_to_back();
      test_random_gaps();

      // Let the pipeline drain before judging the run.
      start <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_features.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
